>>> src/stl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stl_pkg
// Shared types, mode, token kind, error, modifier and base codes for the lexer.
// ----------------------------------------------------------------------------
package stl_pkg;

    localparam int OFFSET_BITS = 32;

    // lexer modes
    localparam logic [4:0] M_IDLE   = 5'd0;
    localparam logic [4:0] M_NAME   = 5'd1;
    localparam logic [4:0] M_ZERO   = 5'd2;
    localparam logic [4:0] M_RUN    = 5'd3;
    localparam logic [4:0] M_INT    = 5'd4;
    localparam logic [4:0] M_FRAC   = 5'd5;
    localparam logic [4:0] M_EXPS   = 5'd6;
    localparam logic [4:0] M_EXPF   = 5'd7;
    localparam logic [4:0] M_EXPD   = 5'd8;
    localparam logic [4:0] M_CFIRST = 5'd9;
    localparam logic [4:0] M_CESC   = 5'd10;
    localparam logic [4:0] M_CCLOSE = 5'd11;
    localparam logic [4:0] M_STR    = 5'd12;
    localparam logic [4:0] M_SESC   = 5'd13;
    localparam logic [4:0] M_OP1    = 5'd14;
    localparam logic [4:0] M_OP2    = 5'd15;

    // token kinds
    localparam logic [7:0] K_EOF    = 8'd0;
    localparam logic [7:0] K_INT    = 8'd128;
    localparam logic [7:0] K_FLOAT  = 8'd129;
    localparam logic [7:0] K_STRING = 8'd130;
    localparam logic [7:0] K_NAME   = 8'd131;
    localparam logic [7:0] K_SHL    = 8'd133;
    localparam logic [7:0] K_SHR    = 8'd134;
    localparam logic [7:0] K_SHL_EQ = 8'd147;
    localparam logic [7:0] K_SHR_EQ = 8'd148;

    // error codes
    localparam logic [3:0] E_NONE     = 4'd0;
    localparam logic [3:0] E_DIGIT    = 4'd1;
    localparam logic [3:0] E_OVERFLOW = 4'd2;
    localparam logic [3:0] E_EXPONENT = 4'd3;
    localparam logic [3:0] E_EMPTY    = 4'd4;
    localparam logic [3:0] E_CNEWLINE = 4'd5;
    localparam logic [3:0] E_ESCAPE   = 4'd6;
    localparam logic [3:0] E_NOCLOSE  = 4'd7;
    localparam logic [3:0] E_SNEWLINE = 4'd8;
    localparam logic [3:0] E_UNTERM   = 4'd9;

    // modifiers
    localparam logic [2:0] MOD_NONE = 3'd0;
    localparam logic [2:0] MOD_HEX  = 3'd1;
    localparam logic [2:0] MOD_BIN  = 3'd2;
    localparam logic [2:0] MOD_OCT  = 3'd3;
    localparam logic [2:0] MOD_CHAR = 3'd4;

    // number base codes
    localparam logic [1:0] B_DEC = 2'd0;
    localparam logic [1:0] B_HEX = 2'd1;
    localparam logic [1:0] B_BIN = 2'd2;
    localparam logic [1:0] B_OCT = 2'd3;

    typedef struct packed {
        logic [7:0]             kind;
        logic [2:0]             modifier;
        logic [63:0]            value;
        logic [OFFSET_BITS-1:0] start_offset;
        logic [OFFSET_BITS-1:0] length;
        logic [3:0]             error;
        logic                   last;
    } token_t;

    // one classified byte: up to two tokens
    typedef struct packed {
        logic   has0;
        token_t tok0;
        logic   has1;
        token_t tok1;
    } pair_t;

endpackage
`default_nettype wire

>>> src/stl_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stl_front
// Accepts source bytes, runs the lexer mode machine and produces up to two
// finished tokens per byte.
// ----------------------------------------------------------------------------
module stl_front
    import stl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  [7:0] ch,
    input  wire logic  end_of_text,
    input  wire logic  take,
    output pair_t      pair
);

    logic [4:0]             mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] start_reg, start_next;
    logic [OFFSET_BITS-1:0] pos_reg, pos_next;
    logic [63:0]            acc_reg, acc_next;
    logic [1:0]             base_reg, base_next;
    logic [2:0]             mod_reg, mod_next;
    logic [7:0]             pch_reg, pch_next;
    logic [3:0]             err_reg, err_next;

    logic        is_dec, is_alpha, is_e, is_space, is_op;
    logic [4:0]  hv;
    logic [7:0]  esc_val;
    logic        esc_ok;
    logic [7:0]  pair_kind;
    logic        absorbed;
    logic        emit_now;
    logic [7:0]  emit_kind;
    logic        emit_end_next;
    logic [3:0]  err_c;
    logic        add_dig;
    logic [63:0] mul_res;
    logic [4:0]  dig;
    logic        ovf;
    logic [1:0]  dig_base;
    logic [OFFSET_BITS-1:0] pos_p1;

    assign pos_p1 = pos_reg + 1'b1;

    // classify the byte
    always_comb
    begin
        is_dec   = (ch >= "0") && (ch <= "9");
        is_alpha = ((ch >= "a") && (ch <= "z")) || ((ch >= "A") && (ch <= "Z"));
        is_e     = (ch == "e") || (ch == "E");
        is_space = (ch == 8'd32) || ((ch >= 8'd9) && (ch <= 8'd13));
        is_op    = (ch == "=") || (ch == "!") || (ch == ":") || (ch == "^") ||
                   (ch == "*") || (ch == "/") || (ch == "%") || (ch == "+") ||
                   (ch == "-") || (ch == "&") || (ch == "|") || (ch == "<") ||
                   (ch == ">");
        if (is_dec)
            hv = 5'(ch - "0");
        else if ((ch >= "a") && (ch <= "f"))
            hv = 5'(ch - "a") + 5'd10;
        else if ((ch >= "A") && (ch <= "F"))
            hv = 5'(ch - "A") + 5'd10;
        else
            hv = 5'd16;
    end

    // escape decode
    always_comb
    begin
        esc_ok = 1'b1;
        unique case (ch)
            "n":     esc_val = 8'd10;
            "r":     esc_val = 8'd13;
            "t":     esc_val = 8'd9;
            "v":     esc_val = 8'd11;
            "b":     esc_val = 8'd8;
            "a":     esc_val = 8'd7;
            "0":     esc_val = 8'd0;
            8'd92:   esc_val = 8'd92;
            8'd39:   esc_val = 8'd39;
            8'd34:   esc_val = 8'd34;
            default:
            begin
                esc_val = 8'd0;
                esc_ok  = 1'b0;
            end
        endcase
    end

    // two-character operator lookup
    always_comb
    begin
        pair_kind = 8'd0;
        if (ch == "=")
        begin
            unique case (pch_reg)
                "=":     pair_kind = 8'd135;
                "!":     pair_kind = 8'd136;
                ":":     pair_kind = 8'd141;
                "^":     pair_kind = 8'd146;
                "*":     pair_kind = 8'd149;
                "/":     pair_kind = 8'd150;
                "%":     pair_kind = 8'd151;
                "+":     pair_kind = 8'd142;
                "-":     pair_kind = 8'd143;
                "&":     pair_kind = 8'd144;
                "|":     pair_kind = 8'd145;
                "<":     pair_kind = 8'd137;
                ">":     pair_kind = 8'd138;
                default: pair_kind = 8'd0;
            endcase
        end
        else if (ch == pch_reg)
        begin
            unique case (pch_reg)
                "+":     pair_kind = 8'd152;
                "-":     pair_kind = 8'd153;
                "&":     pair_kind = 8'd139;
                "|":     pair_kind = 8'd140;
                default: pair_kind = 8'd0;
            endcase
        end
    end

    // digit accumulate: shifts for powers of two, shift-add for ten
    always_comb
    begin
        logic [67:0] wide;
        logic [4:0]  bv;
        wide = 68'd0;
        // a decimal digit after a leading zero already counts in octal
        dig_base = (mode_reg == M_ZERO && is_dec) ? B_OCT : base_reg;
        unique case (dig_base)
            B_DEC: bv = 5'd10;
            B_HEX: bv = 5'd16;
            B_BIN: bv = 5'd2;
            default: bv = 5'd8;
        endcase
        dig = (hv >= bv) ? 5'd0 : hv;
        unique case (dig_base)
            B_DEC:   wide = {1'b0, acc_reg, 3'b0} + {3'b0, acc_reg, 1'b0} + 68'(dig);
            B_HEX:   wide = {acc_reg, 4'b0} + 68'(dig);
            B_BIN:   wide = {3'b0, acc_reg, 1'b0} + 68'(dig);
            default: wide = {1'b0, acc_reg, 3'b0} + 68'(dig);
        endcase
        mul_res = wide[63:0];
        ovf = |wide[67:64];
    end

    // mode machine
    always_comb
    begin
        mode_next     = mode_reg;
        start_next    = start_reg;
        pos_next      = pos_reg;
        acc_next      = acc_reg;
        base_next     = base_reg;
        mod_next      = mod_reg;
        pch_next      = pch_reg;
        err_c         = err_reg;
        absorbed      = 1'b1;
        emit_now      = 1'b0;
        emit_kind     = K_EOF;
        emit_end_next = 1'b0;
        add_dig       = 1'b0;
        pair          = '0;

        if (end_of_text)
        begin
            absorbed = 1'b1;
            unique case (mode_reg)
                M_NAME: begin emit_now = 1'b1; emit_kind = K_NAME; end
                M_ZERO, M_RUN, M_INT: begin emit_now = 1'b1; emit_kind = K_INT; end
                M_FRAC, M_EXPD: begin emit_now = 1'b1; emit_kind = K_FLOAT; end
                M_EXPS, M_EXPF:
                begin
                    emit_now = 1'b1; emit_kind = K_FLOAT;
                    if (err_c == E_NONE) err_c = E_EXPONENT;
                end
                M_CFIRST, M_CESC, M_CCLOSE:
                begin
                    emit_now = 1'b1; emit_kind = K_INT;
                    if (err_c == E_NONE) err_c = E_NOCLOSE;
                end
                M_STR, M_SESC:
                begin
                    emit_now = 1'b1; emit_kind = K_STRING;
                    if (err_c == E_NONE) err_c = E_UNTERM;
                end
                M_OP1: begin emit_now = 1'b1; emit_kind = pch_reg; end
                M_OP2:
                begin
                    emit_now = 1'b1;
                    emit_kind = (pch_reg == "<") ? K_SHL : K_SHR;
                end
                default: emit_now = 1'b0;
            endcase
        end
        else
        begin
            unique case (mode_reg)
                M_NAME:
                    if (!(is_alpha || is_dec || ch == "_"))
                    begin
                        absorbed = 1'b0; emit_now = 1'b1; emit_kind = K_NAME;
                    end
                M_ZERO:
                    if (ch == "x" || ch == "X")
                    begin
                        mod_next = MOD_HEX; base_next = B_HEX; mode_next = M_INT;
                    end
                    else if (ch == "b" || ch == "B")
                    begin
                        mod_next = MOD_BIN; base_next = B_BIN; mode_next = M_INT;
                    end
                    else if (is_dec)
                    begin
                        mod_next = MOD_OCT; base_next = B_OCT; mode_next = M_RUN;
                        add_dig = 1'b1;
                    end
                    else if (ch == ".")
                        mode_next = M_FRAC;
                    else if (is_e)
                        mode_next = M_EXPS;
                    else if (hv < 5'd16)
                    begin
                        add_dig = 1'b1; mode_next = M_INT;
                    end
                    else
                    begin
                        absorbed = 1'b0; emit_now = 1'b1; emit_kind = K_INT;
                    end
                M_RUN:
                    if (is_dec)
                        add_dig = 1'b1;
                    else if (ch == ".")
                        mode_next = M_FRAC;
                    else if (is_e)
                        mode_next = M_EXPS;
                    else if (hv < 5'd16)
                    begin
                        add_dig = 1'b1; mode_next = M_INT;
                    end
                    else
                    begin
                        absorbed = 1'b0; emit_now = 1'b1; emit_kind = K_INT;
                    end
                M_INT:
                    if (hv < 5'd16)
                        add_dig = 1'b1;
                    else
                    begin
                        absorbed = 1'b0; emit_now = 1'b1; emit_kind = K_INT;
                    end
                M_FRAC:
                    if (is_e)
                        mode_next = M_EXPS;
                    else if (!is_dec)
                    begin
                        absorbed = 1'b0; emit_now = 1'b1; emit_kind = K_FLOAT;
                    end
                M_EXPS:
                    if (ch == "+" || ch == "-")
                        mode_next = M_EXPF;
                    else if (is_dec)
                        mode_next = M_EXPD;
                    else
                    begin
                        if (err_c == E_NONE) err_c = E_EXPONENT;
                        absorbed = 1'b0; emit_now = 1'b1; emit_kind = K_FLOAT;
                    end
                M_EXPF:
                    if (is_dec)
                        mode_next = M_EXPD;
                    else
                    begin
                        if (err_c == E_NONE) err_c = E_EXPONENT;
                        absorbed = 1'b0; emit_now = 1'b1; emit_kind = K_FLOAT;
                    end
                M_EXPD:
                    if (!is_dec)
                    begin
                        absorbed = 1'b0; emit_now = 1'b1; emit_kind = K_FLOAT;
                    end
                M_CFIRST:
                begin
                    mode_next = M_CCLOSE;
                    if (ch == 8'd39)
                    begin
                        if (err_c == E_NONE) err_c = E_EMPTY;
                    end
                    else if (ch == 8'd10)
                    begin
                        if (err_c == E_NONE) err_c = E_CNEWLINE;
                    end
                    else if (ch == 8'd92)
                        mode_next = M_CESC;
                    else
                        acc_next = 64'(ch);
                end
                M_CESC:
                begin
                    acc_next = 64'(esc_val);
                    if (!esc_ok && err_c == E_NONE) err_c = E_ESCAPE;
                    mode_next = M_CCLOSE;
                end
                M_CCLOSE:
                    if (ch == 8'd39)
                    begin
                        emit_now = 1'b1; emit_kind = K_INT; emit_end_next = 1'b1;
                    end
                    else
                    begin
                        if (err_c == E_NONE) err_c = E_NOCLOSE;
                        absorbed = 1'b0; emit_now = 1'b1; emit_kind = K_INT;
                    end
                M_STR:
                    if (ch == 8'd34)
                    begin
                        emit_now = 1'b1; emit_kind = K_STRING; emit_end_next = 1'b1;
                    end
                    else if (ch == 8'd10)
                    begin
                        if (err_c == E_NONE) err_c = E_SNEWLINE;
                    end
                    else if (ch == 8'd92)
                        mode_next = M_SESC;
                M_SESC:
                begin
                    if (!esc_ok && err_c == E_NONE) err_c = E_ESCAPE;
                    mode_next = M_STR;
                end
                M_OP1:
                    if ((pch_reg == "<" || pch_reg == ">") && ch == pch_reg)
                        mode_next = M_OP2;
                    else if (pair_kind != 8'd0)
                    begin
                        emit_now = 1'b1; emit_kind = pair_kind; emit_end_next = 1'b1;
                    end
                    else
                    begin
                        absorbed = 1'b0; emit_now = 1'b1; emit_kind = pch_reg;
                    end
                M_OP2:
                    if (ch == "=")
                    begin
                        emit_now = 1'b1; emit_end_next = 1'b1;
                        emit_kind = (pch_reg == "<") ? K_SHL_EQ : K_SHR_EQ;
                    end
                    else
                    begin
                        absorbed = 1'b0; emit_now = 1'b1;
                        emit_kind = (pch_reg == "<") ? K_SHL : K_SHR;
                    end
                default: absorbed = 1'b0;
            endcase
        end

        if (add_dig)
        begin
            if (hv >= 5'(dig) && hv != 5'(dig) && err_c == E_NONE) err_c = E_DIGIT;
            if (ovf && err_c == E_NONE) err_c = E_OVERFLOW;
            acc_next = mul_res;
        end

        // first result: token finished by this byte or by end of text
        pair.has0               = emit_now;
        pair.tok0.kind          = emit_kind;
        pair.tok0.modifier      = (emit_kind == K_INT) ? mod_reg : MOD_NONE;
        pair.tok0.value         = (emit_kind == K_INT) ? acc_reg : 64'd0;
        if (emit_kind == K_INT && (mode_reg == M_CFIRST || mode_reg == M_CESC ||
            mode_reg == M_CCLOSE) && !end_of_text)
            pair.tok0.value = acc_next;
        if (emit_kind == K_INT && mode_reg != M_CFIRST && mode_reg != M_CESC &&
            mode_reg != M_CCLOSE)
            pair.tok0.value = acc_reg;
        pair.tok0.start_offset  = start_reg;
        pair.tok0.length        = (emit_end_next ? pos_p1 : pos_reg) - start_reg;
        pair.tok0.error         = err_c;
        pair.tok0.last          = 1'b0;
        if (emit_now)
            mode_next = M_IDLE;

        if (end_of_text)
        begin
            pair.has1              = 1'b1;
            pair.tok1.kind         = K_EOF;
            pair.tok1.modifier     = MOD_NONE;
            pair.tok1.value        = 64'd0;
            pair.tok1.start_offset = pos_reg;
            pair.tok1.length       = '0;
            pair.tok1.error        = E_NONE;
            pair.tok1.last         = 1'b1;
            mode_next  = M_IDLE;
            start_next = '0;
            pos_next   = '0;
            acc_next   = 64'd0;
            base_next  = B_DEC;
            mod_next   = MOD_NONE;
            pch_next   = 8'd0;
            err_c      = E_NONE;
        end
        else
        begin
            pos_next = pos_p1;
            if (!absorbed)
            begin
                // start a new token with this byte
                start_next = pos_reg;
                acc_next   = 64'd0;
                mod_next   = MOD_NONE;
                base_next  = B_DEC;
                err_c      = E_NONE;
                pch_next   = 8'd0;
                mode_next  = M_IDLE;
                if (is_space || ch == 8'd0 || ch[7])
                    mode_next = M_IDLE;
                else if (is_alpha || ch == "_")
                    mode_next = M_NAME;
                else if (ch == "0")
                    mode_next = M_ZERO;
                else if (is_dec)
                begin
                    mode_next = M_RUN;
                    acc_next  = 64'(hv);
                end
                else if (ch == ".")
                    mode_next = M_FRAC;
                else if (ch == 8'd39)
                begin
                    mode_next = M_CFIRST;
                    mod_next  = MOD_CHAR;
                end
                else if (ch == 8'd34)
                    mode_next = M_STR;
                else if (is_op)
                begin
                    mode_next = M_OP1;
                    pch_next  = ch;
                end
                else
                begin
                    pair.has1              = 1'b1;
                    pair.tok1.kind         = ch;
                    pair.tok1.modifier     = MOD_NONE;
                    pair.tok1.value        = 64'd0;
                    pair.tok1.start_offset = pos_reg;
                    pair.tok1.length       = OFFSET_BITS'(1);
                    pair.tok1.error        = E_NONE;
                    pair.tok1.last         = 1'b1;
                end
            end
        end
        if (!pair.has1)
            pair.tok0.last = 1'b1;
        err_next = err_c;
    end

    // advance state on a transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= M_IDLE;
            start_reg <= '0;
            pos_reg   <= '0;
            acc_reg   <= 64'd0;
            base_reg  <= B_DEC;
            mod_reg   <= MOD_NONE;
            pch_reg   <= 8'd0;
            err_reg   <= E_NONE;
        end
        else if (in_valid && take)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            pos_reg   <= pos_next;
            acc_reg   <= acc_next;
            base_reg  <= base_next;
            mod_reg   <= mod_next;
            pch_reg   <= pch_next;
            err_reg   <= err_next;
        end
    end

endmodule
`default_nettype wire

>>> src/stl_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// stl_back
// Token queue between the classifier and the output port; presents one
// token per cycle while out_stall is low and drains a byte's tokens in order.
// ----------------------------------------------------------------------------
module stl_back
    import stl_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  wire pair_t pair,
    output logic       room,
    output logic       out_valid,
    input  wire logic  out_stall,
    output token_t     tok
);

    localparam int DEPTH = 4;

    token_t     q_reg [DEPTH];
    logic [1:0] rd_reg, rd_next;
    logic [1:0] wr_reg, wr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] n_in;

    assign out_valid = (cnt_reg != 3'd0);
    assign tok       = q_reg[rd_reg];
    assign pop       = out_valid && !out_stall;
    // accept a byte only when both of its tokens fit
    assign room      = (cnt_reg <= 3'(DEPTH - 2));
    assign n_in      = push ? (2'(pair.has0) + 2'(pair.has1)) : 2'd0;

    always_comb
    begin
        rd_next  = rd_reg + 2'(pop);
        wr_next  = wr_reg + n_in;
        cnt_next = cnt_reg + 3'(n_in) - 3'(pop);
    end

    // write queue entries
    always_ff @(posedge clk)
    begin
        if (push && pair.has0)
            q_reg[wr_reg] <= pair.tok0;
        if (push && pair.has1)
            q_reg[wr_reg + 2'(pair.has0)] <= pair.tok1;
    end

    // advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 2'd0;
            wr_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

>>> src/source_token_lexer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// source_token_lexer_top
// C-style lexer: one source byte per transfer in, tokens out.
// ----------------------------------------------------------------------------
// channel  direction  handshake             payload
// in       input      in_valid / in_stall   ch, end_of_text
// out      output     out_valid / out_stall kind, modifier, value,
//                                           start_offset, length, error, last
//
// One byte is taken per cycle while in_stall is low; the classifier works in
// the accept cycle and writes up to two tokens into a four-entry queue. One
// token leaves per cycle while out_stall is low.
// in_stall rises when fewer than two queue entries are free.
// Reset returns the lexer to idle at offset zero and empties the queue.
// ----------------------------------------------------------------------------
module source_token_lexer_top
    import stl_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [7:0]        ch,
    input  wire logic              end_of_text,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [7:0]             kind,
    output logic [2:0]             modifier,
    output logic [63:0]            value,
    output logic [OFFSET_BITS-1:0] start_offset,
    output logic [OFFSET_BITS-1:0] length,
    output logic [3:0]             error,
    output logic                   last
);

    pair_t  pair;
    token_t tok;
    logic   room;

    assign in_stall = !room;

    stl_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .ch          (ch),
        .end_of_text (end_of_text),
        .take        (room),
        .pair        (pair)
    );

    stl_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (in_valid && room),
        .pair      (pair),
        .room      (room),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .tok       (tok)
    );

    assign kind         = tok.kind;
    assign modifier     = tok.modifier;
    assign value        = tok.value;
    assign start_offset = tok.start_offset;
    assign length       = tok.length;
    assign error        = tok.error;
    assign last         = tok.last;

endmodule
`default_nettype wire
